/* rtl/core/nvs_pkg.sv */
// nvs_pkg: shared types, constants and codes for the nearest vertex search core.
// Used by nvs_vertex_mem, nvs_dist_unit and nearest_vertex_search_core.
// No dependencies.
package nvs_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W    = 16;
  localparam int NCOORD     = 4;
  localparam int DIM_SEL_W  = 2;
  localparam int DIMS_W     = 3;
  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int CFG_DATA_W = 11;
  localparam int DIST_W     = 34;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int WORD_W     = NCOORD * COORD_W;

  // Default table depth
  localparam int MAX_VERTICES_DEF = 1024;

  // Saturated distance, also the empty-table answer
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Request command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic REG_DIMS_IN_USE  = 1'b0;
  localparam logic REG_VERTEX_COUNT = 1'b1;

  // Query sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_SQ,
    S_ACC,
    S_CMP,
    S_DONE
  } seq_state_t;

  // Control from the sequencer to the distance unit
  typedef struct packed {
    logic diff_en;
    logic sq_en;
    logic acc_en;
    logic acc_first;
  } dist_ctrl_t;

endpackage

/* rtl/core/nvs_vertex_mem.sv */
// nvs_vertex_mem: vertex table, one write port and one registered read port.
// Depends on nvs_pkg for the word width.
module nvs_vertex_mem #(
  parameter int DEPTH = nvs_pkg::MAX_VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [nvs_pkg::WORD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [nvs_pkg::WORD_W-1:0] rd_data
);

  logic [nvs_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/nvs_dist_unit.sv */
// nvs_dist_unit: shared difference, square and saturating accumulate datapath,
// one coordinate per pass. Depends on nvs_pkg.
module nvs_dist_unit (
  input  logic                                    clk,
  input  nvs_pkg::dist_ctrl_t                     ctrl,
  input  logic [nvs_pkg::DIM_SEL_W-1:0]           dim_sel,
  input  logic [nvs_pkg::NCOORD-1:0][nvs_pkg::COORD_W-1:0] query_pt,
  input  logic [nvs_pkg::WORD_W-1:0]              vertex_word,
  output logic [nvs_pkg::DIST_W-1:0]              acc
);

  logic [nvs_pkg::COORD_W-1:0]      q_sel;
  logic [nvs_pkg::COORD_W-1:0]      v_sel;
  logic signed [nvs_pkg::DIFF_W-1:0] diff_next;
  logic signed [nvs_pkg::DIFF_W-1:0] diff;
  logic signed [nvs_pkg::DIST_W-1:0] sq_full;
  logic [nvs_pkg::DIST_W-1:0]       sq;
  logic [nvs_pkg::DIST_W-1:0]       acc_base;
  logic [nvs_pkg::DIST_W:0]         sum;
  logic [nvs_pkg::DIST_W-1:0]       acc_next;

  // Coordinate select and sign-extended difference
  always_comb begin
    q_sel     = query_pt[dim_sel];
    v_sel     = vertex_word[dim_sel*nvs_pkg::COORD_W +: nvs_pkg::COORD_W];
    diff_next = $signed({q_sel[nvs_pkg::COORD_W-1], q_sel})
              - $signed({v_sel[nvs_pkg::COORD_W-1], v_sel});
  end

  // Square of the difference, always non-negative and below 2^33
  assign sq_full = diff * diff;

  // Saturating accumulate, restarts at the first coordinate
  always_comb begin
    acc_base = ctrl.acc_first ? '0 : acc;
    sum      = {1'b0, acc_base} + {1'b0, sq};
    acc_next = sum[nvs_pkg::DIST_W] ? nvs_pkg::DIST_MAX : sum[nvs_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      diff <= diff_next;
    end
    if (ctrl.sq_en) begin
      sq <= unsigned'(sq_full);
    end
    if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

/* rtl/core/nearest_vertex_search_core.sv */
// nearest_vertex_search_core: top level, query sequencer, config and result register.
// Depends on nvs_pkg, nvs_vertex_mem and nvs_dist_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries write and query requests. A write
//   request (cmd = CMD_WRITE) stores coord_0..coord_3 at vertex_index and
//   yields no result; a slot at or above MAX_VERTICES is dropped.
//   A query request (cmd = CMD_QUERY) scans slots 0..n-1, n = vertex_count
//   capped at MAX_VERTICES, over d = dims_in_use coordinates (clamped to 1..4),
//   and returns nearest_index and min_distance on the output channel
//   (out_valid/out_ready). An empty table gives index 0 and all-ones distance.
//   Each coordinate passes through the one shared difference/square/accumulate
//   unit in three steps, plus a table read and a compare per vertex.
//   The block takes one request at a time; in_ready is high only when idle.
//   The result register lets a new request be taken while a result waits; a
//   finished query holds in its final step until the result register is free.
//   cfg_we/cfg_index/cfg_data write dims_in_use and vertex_count; the user must
//   do so only while idle, as the block does not enforce it. Reset clears
//   control and sets dims_in_use to 2 and vertex_count to 0; the vertex table
//   is not cleared and must be written before it is searched.
module nearest_vertex_search_core #(
  parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [nvs_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [nvs_pkg::INDEX_W-1:0]       vertex_index,
  input  logic signed [nvs_pkg::COORD_W-1:0] coord_0,
  input  logic signed [nvs_pkg::COORD_W-1:0] coord_1,
  input  logic signed [nvs_pkg::COORD_W-1:0] coord_2,
  input  logic signed [nvs_pkg::COORD_W-1:0] coord_3,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nvs_pkg::INDEX_W-1:0]       nearest_index,
  output logic [nvs_pkg::DIST_W-1:0]        min_distance
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  nvs_pkg::seq_state_t state, state_next;

  // Configuration registers
  logic [nvs_pkg::DIMS_W-1:0]  dims_in_use;
  logic [nvs_pkg::COUNT_W-1:0] vertex_count;

  // Query registers
  logic [nvs_pkg::NCOORD-1:0][nvs_pkg::COORD_W-1:0] query_pt;
  logic [CW-1:0]                     n_lim;
  logic [nvs_pkg::DIM_SEL_W-1:0]     dim_last;
  logic [CW-1:0]                     vi;
  logic [nvs_pkg::DIM_SEL_W-1:0]     dim_k;
  logic [AW-1:0]                     best_i;
  logic [nvs_pkg::DIST_W-1:0]        best_d;

  // Control
  logic                              accept;
  logic                              mem_we;
  logic                              rd_en;
  logic                              out_load;
  logic                              last_dim;
  logic                              last_vertex;
  logic                              better;
  nvs_pkg::dist_ctrl_t               dctrl;
  logic [nvs_pkg::WORD_W-1:0]        rd_data;
  logic [nvs_pkg::WORD_W-1:0]        wr_word;
  logic [nvs_pkg::DIST_W-1:0]        acc;
  logic [31:0]                       slot_ext;
  logic [31:0]                       best_ext;
  logic [CW-1:0]                     n_clamp;
  logic [nvs_pkg::DIM_SEL_W-1:0]     dim_clamp;

  assign accept      = in_valid && in_ready;
  assign slot_ext    = 32'(vertex_index);
  assign best_ext    = 32'(best_i);
  assign wr_word     = {coord_3, coord_2, coord_1, coord_0};
  assign last_dim    = (dim_k == dim_last);
  assign last_vertex = ((vi + CW'(1)) == n_lim);
  assign better      = (vi == '0) || (acc < best_d);
  assign out_load    = !out_valid || out_ready;
  assign mem_we      = accept && (cmd == nvs_pkg::CMD_WRITE)
                     && (slot_ext < 32'(MAX_VERTICES));

  // Count capped at table depth, dimensions clamped to 1..4 (stored minus one)
  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_clamp = CW'(MAX_VERTICES);
    end else begin
      n_clamp = CW'(vertex_count);
    end
    if (dims_in_use == '0) begin
      dim_clamp = '0;
    end else if (dims_in_use > nvs_pkg::DIMS_W'(nvs_pkg::NCOORD)) begin
      dim_clamp = nvs_pkg::DIM_SEL_W'(nvs_pkg::NCOORD - 1);
    end else begin
      dim_clamp = nvs_pkg::DIM_SEL_W'(dims_in_use - nvs_pkg::DIMS_W'(1));
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nvs_pkg::S_IDLE: begin
        if (accept && (cmd == nvs_pkg::CMD_QUERY)) begin
          state_next = (n_clamp == '0) ? nvs_pkg::S_DONE : nvs_pkg::S_READ;
        end
      end
      nvs_pkg::S_READ: state_next = nvs_pkg::S_DIFF;
      nvs_pkg::S_DIFF: state_next = nvs_pkg::S_SQ;
      nvs_pkg::S_SQ:   state_next = nvs_pkg::S_ACC;
      nvs_pkg::S_ACC:  state_next = last_dim ? nvs_pkg::S_CMP : nvs_pkg::S_DIFF;
      nvs_pkg::S_CMP:  state_next = last_vertex ? nvs_pkg::S_DONE : nvs_pkg::S_READ;
      nvs_pkg::S_DONE: begin
        if (out_load) begin
          state_next = nvs_pkg::S_IDLE;
        end
      end
      default: state_next = nvs_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready        = 1'b0;
    rd_en           = 1'b0;
    dctrl           = '0;
    case (state)
      nvs_pkg::S_IDLE: in_ready = 1'b1;
      nvs_pkg::S_READ: rd_en = 1'b1;
      nvs_pkg::S_DIFF: dctrl.diff_en = 1'b1;
      nvs_pkg::S_SQ:   dctrl.sq_en = 1'b1;
      nvs_pkg::S_ACC: begin
        dctrl.acc_en    = 1'b1;
        dctrl.acc_first = (dim_k == '0);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nvs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use  <= nvs_pkg::DIMS_W'(2);
      vertex_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nvs_pkg::REG_DIMS_IN_USE:  dims_in_use  <= cfg_data[nvs_pkg::DIMS_W-1:0];
        nvs_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data[nvs_pkg::COUNT_W-1:0];
        default: dims_in_use <= dims_in_use;
      endcase
    end
  end

  // Query capture, scan counters and running best
  always_ff @(posedge clk) begin
    if (rst) begin
      vi    <= '0;
      dim_k <= '0;
    end else begin
      case (state)
        nvs_pkg::S_IDLE: begin
          vi    <= '0;
          dim_k <= '0;
          if (accept) begin
            query_pt <= wr_word;
            n_lim    <= n_clamp;
            dim_last <= dim_clamp;
            best_i   <= '0;
            best_d   <= nvs_pkg::DIST_MAX;
          end
        end
        nvs_pkg::S_ACC: begin
          dim_k <= last_dim ? '0 : dim_k + nvs_pkg::DIM_SEL_W'(1);
        end
        nvs_pkg::S_CMP: begin
          vi <= vi + CW'(1);
          if (better) begin
            best_i <= vi[AW-1:0];
            best_d <= acc;
          end
        end
        default: vi <= vi;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == nvs_pkg::S_DONE) && out_load) begin
      out_valid     <= 1'b1;
      nearest_index <= best_ext[nvs_pkg::INDEX_W-1:0];
      min_distance  <= best_d;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  nvs_vertex_mem #(
    .DEPTH(MAX_VERTICES),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(slot_ext[AW-1:0]),
    .wr_data(wr_word),
    .rd_en  (rd_en),
    .rd_addr(vi[AW-1:0]),
    .rd_data(rd_data)
  );

  nvs_dist_unit u_dist (
    .clk        (clk),
    .ctrl       (dctrl),
    .dim_sel    (dim_k),
    .query_pt   (query_pt),
    .vertex_word(rd_data),
    .acc        (acc)
  );

  // The scan never runs past the table
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == nvs_pkg::S_READ || state == nvs_pkg::S_CMP) |-> (vi < n_lim))
    else $error("scan index beyond vertex count");

  // Dimension counter stays within the active dimensions
  a_dim_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == nvs_pkg::S_DIFF || state == nvs_pkg::S_SQ || state == nvs_pkg::S_ACC)
    |-> (dim_k <= dim_last))
    else $error("dimension counter beyond active dimensions");

  // Table is written only by a request taken while idle
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == nvs_pkg::S_IDLE))
    else $error("table write outside idle");

  // A finished query lands in the result register
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == nvs_pkg::S_DONE && out_load) |=> (out_valid && state == nvs_pkg::S_IDLE))
    else $error("finished query not delivered");

endmodule
